// ===== src/fpp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpp_pkg
// Shared widths, constants and register indexes of the projection unit.
// ---------------------------------------------------------------------------
package fpp_pkg;

	localparam int COORD_W  = 32;
	localparam int ENTRY_W  = 16;
	localparam int ROW_W    = 3 * ENTRY_W;
	localparam int DIST_W   = 16;
	localparam int Q_SHIFT  = 12;
	localparam int PROD_W   = ENTRY_W + COORD_W;
	localparam int SUM_W    = PROD_W + 2;
	localparam int MAG_W    = COORD_W + DIST_W;
	localparam int IDX_W    = 3;
	localparam int IN_W     = 3 * COORD_W;
	localparam int OUT_W    = 72;

	localparam logic signed [COORD_W-1:0] CENTER_U = 32'sd160;
	localparam logic signed [COORD_W-1:0] CENTER_V = 32'sd120;

	localparam logic [IDX_W-1:0] REG_ROT_ROW0    = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROT_ROW1    = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROT_ROW2    = 3'd2;
	localparam logic [IDX_W-1:0] REG_TRANS_X     = 3'd3;
	localparam logic [IDX_W-1:0] REG_TRANS_Y     = 3'd4;
	localparam logic [IDX_W-1:0] REG_TRANS_Z     = 3'd5;
	localparam logic [IDX_W-1:0] REG_SCREEN_DIST = 3'd6;

endpackage

// ===== src/fixed_point_perspective_projection.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fixed_point_perspective_projection
// Rotates a world point by a Q12 matrix, translates it and projects it onto
// the screen with a pipelined restoring divider.
// ---------------------------------------------------------------------------
// channel | dir | beat contents (lowest bits first)
// s_*     | in  | world_x, world_y, world_z
// m_*     | out | visible, screen_u, screen_v, zero pad
// wr_*    | in  | register index, data
//
// One point per cycle while the output is not stalled; the divider gives
// one quotient bit per stage for u and v side by side.
// Reset clears the valid bits and loads the identity matrix, zero translation
// and distance 256. A stall on the output freezes the whole pipeline and
// drops s_tready; nothing is lost or repeated.
module fixed_point_perspective_projection (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [fpp_pkg::IN_W-1:0]  s_tdata,   // world_x, world_y, world_z
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [fpp_pkg::OUT_W-1:0] m_tdata,   // visible, screen_u, screen_v
	input  logic                      wr_en,
	input  logic [fpp_pkg::IDX_W-1:0] wr_index,
	input  logic [fpp_pkg::ROW_W-1:0] wr_data
);
	import fpp_pkg::*;

	logic [ROW_W-1:0]   rot_q [0:2];
	logic [COORD_W-1:0] trans_q [0:2];
	logic [DIST_W-1:0]  dist_q;
	logic               en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0]   <= ROW_W'(4096);
			rot_q[1]   <= ROW_W'(4096) << ENTRY_W;
			rot_q[2]   <= ROW_W'(4096) << (2 * ENTRY_W);
			trans_q[0] <= '0;
			trans_q[1] <= '0;
			trans_q[2] <= '0;
			dist_q     <= DIST_W'(256);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROT_ROW0:    rot_q[0]   <= wr_data;
				REG_ROT_ROW1:    rot_q[1]   <= wr_data;
				REG_ROT_ROW2:    rot_q[2]   <= wr_data;
				REG_TRANS_X:     trans_q[0] <= wr_data[COORD_W-1:0];
				REG_TRANS_Y:     trans_q[1] <= wr_data[COORD_W-1:0];
				REG_TRANS_Z:     trans_q[2] <= wr_data[COORD_W-1:0];
				REG_SCREEN_DIST: dist_q     <= wr_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless the output beat is held
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: nine products
	logic                     v_s1;
	logic signed [PROD_W-1:0] p_s1 [0:2][0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					p_s1[r][c] <= $signed(rot_q[r][c*ENTRY_W +: ENTRY_W])
						* $signed(s_tdata[c*COORD_W +: COORD_W]);
		end
	end

	// stage 2: row sums
	logic                    v_s2;
	logic signed [SUM_W-1:0] sum_s2 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				sum_s2[r] <= SUM_W'(p_s1[r][0]) + SUM_W'(p_s1[r][1]) + SUM_W'(p_s1[r][2]);
		end
	end

	// stage 3: Q12 shift (floor), wrap to 32 bits, translate
	logic               v_s3;
	logic [COORD_W-1:0] cam_s3 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				cam_s3[r] <= sum_s2[r][Q_SHIFT +: COORD_W] + trans_q[r];
		end
	end

	// stage 4: scale by screen distance, depth test
	logic                      v_s4, vis_s4;
	logic signed [MAG_W:0]     pu_s4, pv_s4;
	logic        [COORD_W-1:0] den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pu_s4  <= $signed(cam_s3[0]) * $signed({1'b0, dist_q});
			pv_s4  <= $signed(cam_s3[1]) * $signed({1'b0, dist_q});
			vis_s4 <= $signed(cam_s3[2]) > 32'sd1;
			den_s4 <= cam_s3[2];
		end
	end

	// stage 5: magnitudes and signs
	logic               v_s5, vis_s5, neg_u_s5, neg_v_s5;
	logic [MAG_W-1:0]   mu_s5, mv_s5;
	logic [COORD_W-1:0] den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_u_s5 <= pu_s4[MAG_W];
			neg_v_s5 <= pv_s4[MAG_W];
			mu_s5    <= pu_s4[MAG_W] ? MAG_W'(-pu_s4) : MAG_W'(pu_s4);
			mv_s5    <= pv_s4[MAG_W] ? MAG_W'(-pv_s4) : MAG_W'(pv_s4);
			vis_s5   <= vis_s4;
			den_s5   <= den_s4;
		end
	end

	// divider: one restoring step per stage, u and v in parallel
	logic               dv  [0:MAG_W];
	logic               dvis[0:MAG_W];
	logic               dnu [0:MAG_W];
	logic               dnv [0:MAG_W];
	logic [COORD_W-1:0] dden[0:MAG_W];
	logic [MAG_W-1:0]   nu  [0:MAG_W];
	logic [MAG_W-1:0]   nv  [0:MAG_W];
	logic [MAG_W-1:0]   qu  [0:MAG_W];
	logic [MAG_W-1:0]   qv  [0:MAG_W];
	logic [COORD_W-1:0] ru  [0:MAG_W];
	logic [COORD_W-1:0] rv  [0:MAG_W];

	assign dv[0]   = v_s5;
	assign dvis[0] = vis_s5;
	assign dnu[0]  = neg_u_s5;
	assign dnv[0]  = neg_v_s5;
	assign dden[0] = den_s5;
	assign nu[0]   = mu_s5;
	assign nv[0]   = mv_s5;
	assign qu[0]   = '0;
	assign qv[0]   = '0;
	assign ru[0]   = '0;
	assign rv[0]   = '0;

	for (genvar k = 0; k < MAG_W; k++) begin : g_div
		logic [COORD_W:0] tu, tv;
		logic             geu, gev;

		assign tu  = {ru[k], nu[k][MAG_W-1]};
		assign tv  = {rv[k], nv[k][MAG_W-1]};
		assign geu = tu >= {1'b0, dden[k]};
		assign gev = tv >= {1'b0, dden[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[k+1] <= 1'b0;
			else if (en) dv[k+1] <= dv[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvis[k+1] <= dvis[k];
				dnu[k+1]  <= dnu[k];
				dnv[k+1]  <= dnv[k];
				dden[k+1] <= dden[k];
				nu[k+1]   <= nu[k] << 1;
				nv[k+1]   <= nv[k] << 1;
				qu[k+1]   <= {qu[k][MAG_W-2:0], geu};
				qv[k+1]   <= {qv[k][MAG_W-2:0], gev};
				ru[k+1]   <= geu ? COORD_W'(tu - {1'b0, dden[k]}) : COORD_W'(tu);
				rv[k+1]   <= gev ? COORD_W'(tv - {1'b0, dden[k]}) : COORD_W'(tv);
			end
		end
	end

	// stage 6: restore sign of quotients
	logic                  v_s6, vis_s6;
	logic signed [MAG_W:0] squ_s6, sqv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= dv[MAG_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s6 <= dvis[MAG_W];
			squ_s6 <= dnu[MAG_W] ? -$signed({1'b0, qu[MAG_W]}) : $signed({1'b0, qu[MAG_W]});
			sqv_s6 <= dnv[MAG_W] ? -$signed({1'b0, qv[MAG_W]}) : $signed({1'b0, qv[MAG_W]});
		end
	end

	// centre offset and saturation
	function automatic logic [COORD_W-1:0] sat_add(
		input logic signed [MAG_W:0]   q,
		input logic signed [COORD_W-1:0] c
	);
		logic signed [MAG_W+1:0] s;
		logic signed [MAG_W+1:0] hi, lo;
		begin
			s  = (MAG_W+2)'(q) + (MAG_W+2)'(c);
			hi = (MAG_W+2)'(32'sh7fffffff);
			lo = -(MAG_W+2)'(33'sh080000000);
			if (s > hi)      sat_add = 32'h7fffffff;
			else if (s < lo) sat_add = 32'h80000000;
			else             sat_add = s[COORD_W-1:0];
		end
	endfunction

	// output register
	logic               vis_q;
	logic [COORD_W-1:0] u_q, v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_q <= vis_s6;
			u_q   <= vis_s6 ? sat_add(squ_s6, CENTER_U) : '0;
			v_q   <= vis_s6 ? sat_add(sqv_s6, CENTER_V) : '0;
		end
	end

	assign m_tdata = {(OUT_W - 2*COORD_W - 1)'(0), v_q, u_q, vis_q};

endmodule

// ===== src/fpp_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpp_checker
// Port-level checks of the projection unit, bound to the top level.
// ---------------------------------------------------------------------------
module fpp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [fpp_pkg::OUT_W-1:0] m_tdata
);
	// held output beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// hidden points carry zero coordinates
	a_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[64:1] == 64'd0)
		else $error("hidden point with nonzero coordinates");

	// pad bits are zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:65] == 7'd0)
		else $error("pad bits set");

	// input is open whenever the output is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input blocked with free output");

endmodule

bind fixed_point_perspective_projection fpp_checker u_fpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
